/* src/multi_waveform_oscillator_core_macros.svh */
// Assertion macros for the multi-waveform oscillator core.
`ifndef MULTI_WAVEFORM_OSCILLATOR_CORE_MACROS_SVH
`define MULTI_WAVEFORM_OSCILLATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define MWO_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("oscillator check failed");
`define MWO_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> cons) \
    else $error("oscillator check failed");
`else
`define MWO_ASSERT_IMPLY(label, ante, cons)
`define MWO_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* src/mwo_pkg.sv */
// Shared types and constants of the multi-waveform oscillator.
`timescale 1ns / 1ps
`default_nettype none
package mwo_pkg;
  typedef enum logic [2:0] {
    MODE_SINE, MODE_TRI, MODE_RECT, MODE_RAMP, MODE_SAW, MODE_ORGAN, MODE_PIANO, MODE_BYPASS
  } mode_e;

  typedef enum logic [2:0] {
    REG_MODE, REG_VOLUME, REG_FREQ, REG_PHASE, REG_PW, REG_CENTER, REG_RANGE, REG_BYPASS
  } reg_e;

  localparam int unsigned SIN_LAT = 8;
  localparam int unsigned WAVE_W = 18;

  localparam logic [30:0] SIN_C1 = 31'd1686629713;
  localparam logic [30:0] SIN_C3 = 31'd693598668;
  localparam logic [30:0] SIN_C5 = 31'd85569306;
  localparam logic [30:0] SIN_C7 = 31'd5026995;
  localparam logic [30:0] SIN_C9 = 31'd172272;
endpackage
`default_nettype wire

/* src/mwo_sine.sv */
// Pipelined sine evaluator: quarter-wave fold and degree-9 odd polynomial.
`timescale 1ns / 1ps
`default_nettype none
module mwo_sine import mwo_pkg::*; #(
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  logic                     clk_i,
  input  logic [31:0]              angle_i,
  output logic signed [WAVE_W-1:0] wave_o
);
  localparam logic [31:0] KEEP = ~((32'd1 << (32 - SINE_TABLE_BITS)) - 32'd1);
  localparam logic [30:0] QUARTER = 31'h4000_0000;
  localparam logic [30:0] COEF [4] = '{SIN_C7, SIN_C5, SIN_C3, SIN_C1};

  logic [31:0] am;
  logic [30:0] x_q [0:5];
  logic [1:0]  q_q [0:6];
  logic [30:0] z_q [1:4];
  logic [30:0] p_q [2:5];
  logic [31:0] s_q;
  logic signed [WAVE_W-1:0] w_q;
  logic [61:0] zz;
  logic [61:0] xp;
  logic [32:0] rs;
  logic [18:0] rsh;
  logic [16:0] mag;

  assign am = angle_i & KEEP;
  assign zz = x_q[0] * x_q[0];
  assign xp = x_q[5] * p_q[5];
  assign rs = {1'b0, s_q} + 33'h2000;
  assign rsh = rs[32:14];
  assign mag = (rsh > 19'd65536) ? 17'd65536 : rsh[16:0];

  always_ff @(posedge clk_i) begin
    q_q[0] <= am[31:30];
    x_q[0] <= am[30] ? (QUARTER - {1'b0, am[29:0]}) : {1'b0, am[29:0]};
    z_q[1] <= zz[60:30];
    x_q[1] <= x_q[0];
    q_q[1] <= q_q[0];
    s_q    <= xp[61:30];
    q_q[6] <= q_q[5];
    w_q    <= q_q[6][1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  for (genvar t = 2; t <= 5; t++) begin : g_horner
    logic [30:0] pin;
    logic [61:0] prod;
    if (t == 2) begin : g_first
      assign pin = SIN_C9;
    end else begin : g_next
      assign pin = p_q[t-1];
    end
    assign prod = z_q[t-1] * pin;
    always_ff @(posedge clk_i) begin
      p_q[t] <= 31'({1'b0, COEF[t-2]} - prod[61:30]);
      x_q[t] <= x_q[t-1];
      q_q[t] <= q_q[t-1];
    end
    if (t <= 4) begin : g_z
      always_ff @(posedge clk_i) begin
        z_q[t] <= z_q[t-1];
      end
    end
  end

  assign wave_o = w_q;
endmodule
`default_nettype wire

/* src/mwo_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with sideband.
`timescale 1ns / 1ps
`default_nettype none
module mwo_div #(
  parameter int unsigned DW = 33,
  parameter int unsigned VW = 17,
  parameter int unsigned QW = 18,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quot_o,
  output logic [SW-1:0] side_o
);
  localparam int unsigned CW = VW + QW;

  logic          vld_q [QW];
  logic [DW-1:0] rem_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic [VW-1:0] dsr_q [QW];
  logic [SW-1:0] sd_q  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic          vin;
    logic [DW-1:0] rem_in;
    logic [QW-1:0] quo_in;
    logic [VW-1:0] dsr_in;
    logic [SW-1:0] sd_in;
    logic [CW-1:0] trial;
    logic [CW-1:0] diff;
    logic          fits;
    if (k == 0) begin : g_first
      assign vin    = valid_i;
      assign rem_in = dividend_i;
      assign quo_in = '0;
      assign dsr_in = divisor_i;
      assign sd_in  = side_i;
    end else begin : g_next
      assign vin    = vld_q[k-1];
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
      assign dsr_in = dsr_q[k-1];
      assign sd_in  = sd_q[k-1];
    end
    assign trial = CW'(dsr_in) << (QW - 1 - k);
    assign fits  = CW'(rem_in) >= trial;
    assign diff  = CW'(rem_in) - trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= fits ? diff[DW-1:0] : rem_in;
      quo_q[k] <= quo_in | (fits ? (QW'(1) << (QW - 1 - k)) : '0);
      dsr_q[k] <= dsr_in;
      sd_q[k]  <= sd_in;
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quot_o  = quo_q[QW-1];
  assign side_o  = sd_q[QW-1];
endmodule
`default_nettype wire

/* src/multi_waveform_oscillator_core.sv */
// Top level of the multi-waveform oscillator: config port and sample pipeline.
`timescale 1ns / 1ps
`default_nettype none
`include "multi_waveform_oscillator_core_macros.svh"
// The core takes one time stamp per clock (busy stays low) and returns its
// sample through the pipeline, one done_o pulse per time stamp, in order.
// The longest parts are the sine polynomial pipeline (8 stages) and
// the restoring triangle slope divider that settles one quotient bit per stage
// (18 stages). Gain scaling takes 6 stages and divides by a reciprocal
// multiply. The phase, weighting and output registers complete the pipeline.
// Results cannot be held off: take sample_o and saturated_o in the cycle
// done_o is high. Write registers only while no time stamp is in flight.
module multi_waveform_oscillator_core import mwo_pkg::*; #(
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        time_stamp_i,
  output logic               done_o,
  output logic signed [23:0] sample_o,
  output logic               saturated_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  localparam int unsigned TRI_DW = 33;
  localparam int unsigned TRI_VW = 17;
  localparam int unsigned TRI_QW = 18;
  localparam int unsigned GAIN_QW = 22;
  localparam int unsigned GAIN_LAT = 2;
  localparam int unsigned LAT = 2 + SIN_LAT + 1 + TRI_QW + 4 + GAIN_LAT + 1;
  localparam logic [31:0] GAIN_RECIP = 32'd3518437209;
  localparam logic [54:0] GAIN_HALF = 55'd81920000;
  localparam logic [7:0] VOL_MAX = 8'd200;
  localparam logic signed [17:0] ONE18 = 18'sd65536;
  localparam logic signed [19:0] ONE20 = 20'sd65536;

  typedef struct packed {
    logic signed [17:0] wdir;
    logic [32:0]        tnum;
    logic [16:0]        tdiv;
    logic               tbr;
  } side_t;

  mode_e       mode_q;
  logic [7:0]  volume_q;
  logic [23:0] freq_q;
  logic [16:0] phase_q;
  logic [16:0] pw_q;
  logic [15:0] center_q;
  logic [15:0] range_q;
  logic [15:0] bypass_q;
  logic        wr;

  assign wr     = psel & penable & pwrite & pready;
  assign pready = 1'b1;
  assign busy   = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_SINE;
      volume_q <= 8'd100;
      freq_q   <= 24'd112640;
      phase_q  <= 17'd0;
      pw_q     <= 17'd32768;
      center_q <= 16'd0;
      range_q  <= 16'd16384;
      bypass_q <= 16'd0;
    end else if (wr) begin
      case (reg_e'(paddr[4:2]))
        REG_MODE:   mode_q   <= mode_e'(pwdata[2:0]);
        REG_VOLUME: volume_q <= pwdata[7:0];
        REG_FREQ:   freq_q   <= pwdata[23:0];
        REG_PHASE:  phase_q  <= pwdata[16:0];
        REG_PW:     pw_q     <= pwdata[16:0];
        REG_CENTER: center_q <= pwdata[15:0];
        REG_RANGE:  range_q  <= pwdata[15:0];
        REG_BYPASS: bypass_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_e'(paddr[4:2]))
      REG_MODE:   prdata = {29'd0, mode_q};
      REG_VOLUME: prdata = {24'd0, volume_q};
      REG_FREQ:   prdata = {8'd0, freq_q};
      REG_PHASE:  prdata = {15'd0, phase_q};
      REG_PW:     prdata = {15'd0, pw_q};
      REG_CENTER: prdata = {16'd0, center_q};
      REG_RANGE:  prdata = {16'd0, range_q};
      REG_BYPASS: prdata = {16'd0, bypass_q};
      default:    prdata = 32'd0;
    endcase
  end

  // Values derived from the registers alone
  logic [7:0]  volc;
  logic [15:0] vsq_q;
  logic [40:0] fpm;
  logic [40:0] fwm;
  logic [31:0] fp_q;
  logic [31:0] fw_q;

  assign volc = (volume_q > VOL_MAX) ? VOL_MAX : volume_q;
  assign fpm  = freq_q * phase_q;
  assign fwm  = freq_q * pw_q;

  always_ff @(posedge clk_i) begin
    vsq_q <= volc * volc;
    fp_q  <= {fpm[23:0], 8'd0};
    fw_q  <= {fwm[23:0], 8'd0};
  end

  // Phase accumulation
  logic        v1_q, v2_q;
  logic [55:0] bprod;
  logic [31:0] base1_q, base2_q, u2_q;

  assign bprod = time_stamp_i * freq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= start & ~busy;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    base1_q <= bprod[31:0];
    base2_q <= base1_q;
    u2_q    <= base1_q + {phase_q[15:0], 16'd0};
  end

  // Sine lanes
  logic [31:0] ang [5];
  logic signed [WAVE_W-1:0] sw [5];

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      ang[i] = u2_q;
    end
    case (mode_q)
      MODE_ORGAN: begin
        ang[0] = u2_q + {pw_q[15:0], 16'd0};
        ang[1] = u2_q << 1;
        ang[3] = u2_q >> 1;
        ang[4] = u2_q >> 2;
      end
      MODE_PIANO: begin
        ang[0] = base2_q + fp_q;
        ang[1] = base2_q;
        ang[2] = base2_q;
        ang[3] = base2_q;
        ang[4] = base2_q + fw_q;
      end
      default: ;
    endcase
  end

  for (genvar l = 0; l < 5; l++) begin : g_lane
    mwo_sine #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_sine (
      .clk_i  (clk_i),
      .angle_i(ang[l]),
      .wave_o (sw[l])
    );
  end

  // Direct waveforms and triangle operands
  side_t       side;
  logic [16:0] pcl, qcl;
  logic [32:0] pshift, pdiff;

  always_comb begin
    if (pw_q == 17'd0) begin
      pcl = 17'd1;
    end else if (pw_q > 17'd65536) begin
      pcl = 17'd65536;
    end else begin
      pcl = pw_q;
    end
    if (pw_q >= 17'd65536) begin
      qcl = 17'd1;
    end else begin
      qcl = 17'd65536 - pw_q;
    end
    pshift    = {pcl, 16'd0};
    pdiff     = {1'b0, u2_q} - pshift;
    side.tbr  = {1'b0, u2_q} < pshift;
    side.tnum = side.tbr ? {u2_q, 1'b0} : {pdiff[31:0], 1'b0};
    side.tdiv = side.tbr ? pcl : qcl;
    case (mode_q)
      MODE_RECT: side.wdir = ({1'b0, u2_q} <= {pw_q, 16'd0}) ? ONE18 : -ONE18;
      MODE_RAMP: side.wdir = $signed({1'b0, u2_q[31:15]}) - ONE18;
      MODE_SAW:  side.wdir = ONE18 - $signed({1'b0, u2_q[31:15]});
      default:   side.wdir = 18'sd0;
    endcase
  end

  side_t            sd_q [SIN_LAT];
  logic [SIN_LAT-1:0] sv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= '0;
    end else begin
      sv_q <= {sv_q[SIN_LAT-2:0], v2_q};
    end
  end

  always_ff @(posedge clk_i) begin
    sd_q[0] <= side;
    for (int i = 1; i < SIN_LAT; i++) begin
      sd_q[i] <= sd_q[i-1];
    end
  end

  // Lane weighting, truncated toward zero
  logic signed [19:0] we [5];
  logic signed [19:0] wh [5];
  logic signed [19:0] wq [5];
  logic signed [19:0] wsum;

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      we[i] = 20'(sw[i]);
      wh[i] = (we[i] + (we[i] < 0 ? 20'sd1 : 20'sd0)) >>> 1;
      wq[i] = (we[i] + (we[i] < 0 ? 20'sd3 : 20'sd0)) >>> 2;
    end
    case (mode_q)
      MODE_SINE:  wsum = we[2];
      MODE_ORGAN: wsum = wq[0] + wh[1] + we[2] + wh[3] + wq[4];
      MODE_PIANO: wsum = wh[0] + we[2] + wh[4];
      default:    wsum = 20'(sd_q[SIN_LAT-1].wdir);
    endcase
  end

  logic               v3_q;
  logic signed [19:0] wa3_q;
  logic [32:0]        tnum3_q;
  logic [16:0]        tdiv3_q;
  logic               tbr3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= sv_q[SIN_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    wa3_q   <= wsum;
    tnum3_q <= sd_q[SIN_LAT-1].tnum;
    tdiv3_q <= sd_q[SIN_LAT-1].tdiv;
    tbr3_q  <= sd_q[SIN_LAT-1].tbr;
  end

  logic              tv;
  logic [TRI_QW-1:0] tq;
  logic [20:0]       tside;

  mwo_div #(.DW(TRI_DW), .VW(TRI_VW), .QW(TRI_QW), .SW(21)) u_tri_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (v3_q),
    .dividend_i(tnum3_q),
    .divisor_i (tdiv3_q),
    .side_i    ({wa3_q, tbr3_q}),
    .valid_o   (tv),
    .quot_o    (tq),
    .side_o    (tside)
  );

  // Scaling
  logic               v4_q, v5_q, v6_q, v7_q, v8_q, v9_q;
  logic signed [19:0] tqs, w4_d, w4_q;
  logic signed [36:0] rprod, cext, s5_q;
  logic signed [53:0] nprod, num6_q;
  logic [53:0]        mag7_q;
  logic               neg7_q, neg8_q, neg9_q;
  logic [54:0]        tsum;
  logic [30:0]        n8_q;
  logic [62:0]        gprod9_q;

  assign tqs   = $signed({2'b00, tq});
  assign w4_d  = (mode_q == MODE_TRI) ? (tside[0] ? (ONE20 - tqs) : (tqs - ONE20))
                                      : $signed(tside[20:1]);
  assign rprod = $signed(range_q) * w4_q;
  assign cext  = {{5{center_q[15]}}, center_q, 16'd0};
  assign nprod = s5_q * $signed({1'b0, vsq_q});
  assign tsum  = {1'b0, mag7_q} + GAIN_HALF;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      v9_q <= 1'b0;
    end else begin
      v4_q <= tv;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
      v9_q <= v8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    w4_q     <= w4_d;
    s5_q     <= rprod + cext;
    num6_q   <= nprod;
    neg7_q   <= num6_q[53];
    mag7_q   <= num6_q[53] ? 54'(-num6_q) : 54'(num6_q);
    n8_q     <= tsum[48:18];
    neg8_q   <= neg7_q;
    gprod9_q <= n8_q * GAIN_RECIP;
    neg9_q   <= neg8_q;
  end

  logic               gv;
  logic [GAIN_QW-1:0] gq;
  logic               gneg;

  assign gv   = v9_q;
  assign gq   = gprod9_q[62:41];
  assign gneg = neg9_q;

  // Rounding result, saturation and bypass
  logic [23:0]        gmag;
  logic               sat;
  logic signed [23:0] res;
  logic               byp;
  logic               done_q;
  logic signed [23:0] sample_q;
  logic               sat_q;

  assign gmag = 24'(gq);
  assign sat  = gneg ? (gmag > 24'd8388608) : (gmag > 24'd8388607);
  assign byp  = (mode_q == MODE_BYPASS) || (volume_q == 8'd0);

  always_comb begin
    if (sat) begin
      res = gneg ? 24'sh800000 : 24'sh7FFFFF;
    end else begin
      res = gneg ? -$signed(gmag) : $signed(gmag);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= gv;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= byp ? {{6{bypass_q[15]}}, bypass_q, 2'b00} : res;
    sat_q    <= byp ? 1'b0 : sat;
  end

  assign done_o      = done_q;
  assign sample_o    = sample_q;
  assign saturated_o = sat_q;

  `MWO_ASSERT_NEXT(a_fixed_latency, start && !busy, ##(LAT-1) done_o)
  `MWO_ASSERT_IMPLY(a_done_has_origin, done_o, $past(start && !busy, LAT))
  `MWO_ASSERT_IMPLY(a_bypass_unclipped, done_o && byp, !saturated_o)
endmodule
`default_nettype wire
